[src/psbc_pkg.sv]
// Shared constants, types and helper functions for the pendulum swing-up and balance controller.
// Also holds the cos and tanh table generators. Every other file imports this package.
package psbc_pkg;

    localparam int FRAC_BITS     = 16;
    localparam int TABLE_ENTRIES = 256;
    localparam int TW            = $clog2(TABLE_ENTRIES);
    localparam int CW            = FRAC_BITS + 2;   // table entry width, holds +-1.0
    localparam int DW            = 24;              // input and state field width
    localparam int GW            = 32;              // gain register width
    localparam int MW            = 34;              // multiplier operand width
    localparam int PW            = 2 * MW;          // product width
    localparam int AW            = 60;              // LQR accumulator width
    localparam int UW            = 46;              // balance force before saturation
    localparam int OUT_W         = 22;
    localparam int CFG_W         = 3;

    localparam logic [CFG_W-1:0] CFG_GAIN_POSITION   = 3'd0;
    localparam logic [CFG_W-1:0] CFG_GAIN_VELOCITY   = 3'd1;
    localparam logic [CFG_W-1:0] CFG_GAIN_ANGLE      = 3'd2;
    localparam logic [CFG_W-1:0] CFG_GAIN_RATE       = 3'd3;
    localparam logic [CFG_W-1:0] CFG_TARGET_POSITION = 3'd4;
    localparam logic [CFG_W-1:0] CFG_TARGET_VELOCITY = 3'd5;
    localparam logic [CFG_W-1:0] CFG_TARGET_RATE     = 3'd6;

    localparam longint PI_Q30         = 64'sd3373259426;
    localparam longint HALFPI_Q30     = 64'sd1686629713;
    localparam longint INV2PI_Q32     = 64'sd683565276;
    localparam longint EINV_Q30       = 64'sd395007542;
    localparam longint HALF_I_Q30     = 64'sd2501818;
    localparam longint MGL_Q30        = 64'sd328315772;
    localparam longint KSWING_Q30     = 64'sd2313913631;
    localparam longint COS_GATE_Q30   = 64'sd858993459;
    localparam longint LATCH_LO_Q30   = 64'sd3279561865;
    localparam longint LATCH_HI_Q30   = 64'sd3466962026;
    localparam longint DRIFT_Q40      = 64'sd3848291;
    localparam longint VEL_SMALL_Q30  = 64'sd53687091;
    localparam longint FORCE_SMALL_Q30 = 64'sd10737418;
    localparam longint COMP_SIGN_Q30  = 64'sd2254857830;
    localparam longint COMP_TANH_Q30  = 64'sd2791728742;
    localparam longint TANH_SCALE     = 64'sd100 * TABLE_ENTRIES;

    typedef logic signed [CW-1:0] rom_t [TABLE_ENTRIES];

    // Q30 constant to Q(FRAC_BITS), rounded.
    function automatic longint qf(input longint c30);
        return (c30 + (longint'(1) <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
    endfunction

    localparam longint QF_ONE       = longint'(1) <<< FRAC_BITS;
    localparam longint QF_PI        = qf(PI_Q30);
    localparam longint QF_COS_GATE  = qf(COS_GATE_Q30);
    localparam longint QF_LATCH_LO  = qf(LATCH_LO_Q30);
    localparam longint QF_LATCH_HI  = qf(LATCH_HI_Q30);
    localparam longint QF_VEL_SMALL = qf(VEL_SMALL_Q30);
    localparam longint QF_F_SMALL   = qf(FORCE_SMALL_Q30);
    localparam longint QF_COMP_SIGN = qf(COMP_SIGN_Q30);
    localparam longint SWING_SAT    = longint'(20) <<< FRAC_BITS;
    localparam longint BAL_SAT      = longint'(25) <<< FRAC_BITS;
    localparam longint Q_LIM        = longint'(64) <<< FRAC_BITS;
    localparam longint S24_MAX      = 64'sd8388607;
    localparam longint S24_MIN      = -64'sd8388608;

    // Arithmetic right shift with rounding to nearest, ties away from zero.
    function automatic logic signed [PW-1:0] rshr(input logic signed [PW-1:0] v, input int s);
        logic signed [PW-1:0] h;
        logic signed [PW-1:0] t;
        h = PW'(1) << (s - 1);
        t = v + h;
        if (v[PW-1])
            t = t - PW'(1);
        return t >>> s;
    endfunction

    function automatic logic signed [PW-1:0] clip(input logic signed [PW-1:0] v,
                                                  input longint lim);
        logic signed [PW-1:0] hi;
        hi = PW'(lim);
        if (v > hi)
            return hi;
        else if (v < -hi)
            return -hi;
        return v;
    endfunction

    function automatic longint rshr_l(input longint v, input int s);
        longint mag;
        longint r;
        mag = (v < 0) ? -v : v;
        r = (mag + (longint'(1) <<< (s - 1))) >>> s;
        return (v < 0) ? -r : r;
    endfunction

    // Long division of non-negative operands by shift and subtract, for the table generators.
    function automatic longint udiv(input longint n, input longint d);
        longint q;
        longint r;
        q = 0;
        r = 0;
        for (int i = 62; i >= 0; i--)
        begin
            r = (r <<< 1) | ((n >>> i) & longint'(1));
            if (r >= d)
            begin
                r = r - d;
                q = q | (longint'(1) <<< i);
            end
        end
        return q;
    endfunction

    // Cosine of a turn fraction (Q0.32), result in Q30, by a Taylor series.
    function automatic longint cos_turn_q30(input longint t);
        longint q;
        longint a;
        longint x;
        longint x2;
        longint mag;
        longint sum;
        bit     neg;
        q = t >>> 30;
        a = t & 64'h3FFF_FFFF;
        neg = (q == 1) || (q == 2);
        if (q == 1 || q == 3)
            a = (longint'(1) <<< 30) - a;
        x = (a * HALFPI_Q30) >>> 30;
        x2 = (x * x) >>> 30;
        mag = longint'(1) <<< 30;
        sum = mag;
        for (int k = 1; k <= 10; k++)
        begin
            mag = udiv((mag * x2) >>> 30, longint'((2 * k - 1) * (2 * k)));
            sum = (k % 2 == 1) ? sum - mag : sum + mag;
        end
        if (sum < 0)
            sum = 0;
        if (sum > (longint'(1) <<< 30))
            sum = longint'(1) <<< 30;
        return neg ? -sum : sum;
    endfunction

    function automatic longint exp_neg_q30(input longint z);
        longint n;
        longint f;
        longint mag;
        longint sum;
        longint r;
        n = z >>> 30;
        f = z & 64'h3FFF_FFFF;
        mag = longint'(1) <<< 30;
        sum = mag;
        if (n > 40)
            return 0;
        for (int k = 1; k <= 12; k++)
        begin
            mag = udiv((mag * f) >>> 30, longint'(k));
            sum = (k % 2 == 1) ? sum - mag : sum + mag;
        end
        if (sum < 0)
            sum = 0;
        if (sum > (longint'(1) <<< 30))
            sum = longint'(1) <<< 30;
        r = sum;
        for (longint k = 0; k < n; k++)
            r = (r * EINV_Q30 + (longint'(1) <<< 29)) >>> 30;
        return r;
    endfunction

    function automatic rom_t make_cos_rom();
        rom_t   rom;
        longint t;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            t = (longint'(i) <<< 32) / TABLE_ENTRIES;
            rom[i] = CW'(rshr_l(cos_turn_q30(t), 30 - FRAC_BITS));
        end
        return rom;
    endfunction

    // tanh(8*i/N) via (1 - e^-2x) / (1 + e^-2x).
    function automatic rom_t make_tanh_rom();
        rom_t   rom;
        longint e;
        longint th;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            e = exp_neg_q30((longint'(i) <<< 34) / TABLE_ENTRIES);
            th = udiv(((longint'(1) <<< 30) - e) <<< 30, (longint'(1) <<< 30) + e);
            rom[i] = CW'(rshr_l(th, 30 - FRAC_BITS));
        end
        return rom;
    endfunction

endpackage

[src/pendulum_swingup_balance_controller.sv]
// Pendulum swing-up and balance controller: one force setpoint per state beat.
// Built from psbc_pkg, the shared multiplier psbc_mul and the lookup tables psbc_tables.
//
// Each input beat carries angle, rate, cart position and cart velocity (signed Q8.16) and
// yields exactly one output beat with the force (Q6.16, within +-25 N) and the balance flag.
// All products go through one registered 34x34 multiplier under a small sequencer, and each
// dependent step waits for the registered product, so a new beat is taken only after the
// sequencer has finished the previous one. Swing-up mode skips its pumping steps when the
// cosine gate is closed, and a beat with angle and rate both zero goes straight to the done
// state. A stalled output holds the sequencer in its done state. The input is ready only
// while the sequencer is idle; a finished result waits in the output register while the next
// beat is taken. Configuration writes belong between beats.
module pendulum_swingup_balance_controller
    import psbc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_index,
    input  logic [GW-1:0]    cfg_data,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [95:0]      s_tdata,   // pend_angle, pend_rate, cart_position, cart_velocity
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [23:0]      m_tdata,   // force_res, zero fill
    output logic [0:0]       m_tuser    // balancing
);

    localparam logic [4:0] ST_IDLE    = 5'd0;
    localparam logic [4:0] ST_COS_M   = 5'd1;
    localparam logic [4:0] ST_COS_IDX = 5'd2;
    localparam logic [4:0] ST_KE_WW   = 5'd3;
    localparam logic [4:0] ST_KE_M    = 5'd4;
    localparam logic [4:0] ST_KE      = 5'd5;
    localparam logic [4:0] ST_PE_M    = 5'd6;
    localparam logic [4:0] ST_GATE    = 5'd7;
    localparam logic [4:0] ST_P_M     = 5'd8;
    localparam logic [4:0] ST_P       = 5'd9;
    localparam logic [4:0] ST_Q_M     = 5'd10;
    localparam logic [4:0] ST_Q       = 5'd11;
    localparam logic [4:0] ST_K_M     = 5'd12;
    localparam logic [4:0] ST_SW_END  = 5'd13;
    localparam logic [4:0] ST_DR_M    = 5'd14;
    localparam logic [4:0] ST_DR      = 5'd15;
    localparam logic [4:0] ST_E1      = 5'd16;
    localparam logic [4:0] ST_E2      = 5'd17;
    localparam logic [4:0] ST_E3      = 5'd18;
    localparam logic [4:0] ST_E4      = 5'd19;
    localparam logic [4:0] ST_E5      = 5'd20;
    localparam logic [4:0] ST_TH_M    = 5'd21;
    localparam logic [4:0] ST_TH_IDX  = 5'd22;
    localparam logic [4:0] ST_TH_SEL  = 5'd23;
    localparam logic [4:0] ST_TC_M    = 5'd24;
    localparam logic [4:0] ST_BAL_END = 5'd25;
    localparam logic [4:0] ST_DONE    = 5'd26;

    logic [4:0] state_reg;
    logic [4:0] state_next;

    logic signed [GW-1:0] gain_position_reg;
    logic signed [GW-1:0] gain_velocity_reg;
    logic signed [GW-1:0] gain_angle_reg;
    logic signed [GW-1:0] gain_rate_reg;
    logic signed [DW-1:0] target_position_reg;
    logic signed [DW-1:0] target_velocity_reg;
    logic signed [DW-1:0] target_rate_reg;

    logic                 bal_reg;
    logic signed [DW-1:0] at_reg;
    logic signed [DW-1:0] at_next;
    logic                 m_tvalid_reg;

    logic signed [DW-1:0]    a_reg;
    logic signed [DW-1:0]    w_reg;
    logic signed [DW-1:0]    x_reg;
    logic signed [DW-1:0]    v_reg;
    logic signed [CW-1:0]    c_reg;
    logic signed [MW-1:0]    r1_reg;
    logic signed [MW-1:0]    r2_reg;
    logic signed [AW-1:0]    acc_reg;
    logic signed [UW-1:0]    u_reg;
    logic signed [OUT_W-1:0] force_reg;
    logic                    gate_reg;
    logic                    sat_reg;
    logic [OUT_W-1:0]        m_force_reg;
    logic                    m_bal_reg;

    logic signed [MW-1:0] mul_a;
    logic signed [MW-1:0] mul_b;
    logic signed [PW-1:0] prod;
    logic [TW-1:0]        cos_idx;
    logic [TW-1:0]        tanh_idx;
    logic signed [CW-1:0] cos_q;
    logic signed [CW-1:0] tanh_q;

    logic signed [PW-1:0] sh_f;
    logic signed [PW-1:0] sh_30;
    logic signed [PW-1:0] sh_40;
    logic signed [PW-1:0] acc_sh;
    logic signed [PW-1:0] drift_sum;
    logic [31:0]          turn_frac;
    logic signed [PW-1:0] tanh_sum;
    logic signed [DW:0]   v_abs;
    logic signed [UW-1:0] u_abs;
    logic signed [UW-1:0] u_comp;
    logic signed [PW-1:0] bal_force;
    logic                 in_zero;
    logic                 out_free;
    logic                 latch_hit;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_zero  = (s_tdata[23:0] == '0) && (s_tdata[47:24] == '0);
    assign out_free = !m_tvalid_reg || m_tready;

    psbc_mul u_mul
    (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    psbc_tables u_tables
    (
        .clk      (clk),
        .cos_idx  (cos_idx),
        .tanh_idx (tanh_idx),
        .cos_q    (cos_q),
        .tanh_q   (tanh_q)
    );

    assign sh_f   = rshr(prod, FRAC_BITS);
    assign sh_30  = rshr(prod, 30);
    assign sh_40  = rshr(prod, 40);
    assign acc_sh = rshr(PW'(acc_reg), 16);

    // Angle times 1/(2*pi) gives turns; round to the nearest table entry with wrap.
    assign turn_frac = prod[FRAC_BITS+31:FRAC_BITS];
    assign cos_idx   = turn_frac[31 -: TW] + TW'(turn_frac[31-TW]);

    assign tanh_sum = prod + (PW'(1) << (FRAC_BITS + 2));
    assign tanh_idx = tanh_sum[FRAC_BITS+3+TW-1:FRAC_BITS+3];

    // The target saturates to the full 24-bit signed range.
    assign drift_sum = PW'(at_reg) + sh_40;
    assign at_next   = (drift_sum > PW'(S24_MAX)) ? DW'(S24_MAX) :
                       (drift_sum < PW'(S24_MIN)) ? DW'(S24_MIN) : DW'(drift_sum);

    assign latch_hit = (PW'(a_reg) >= PW'(QF_LATCH_LO)) && (PW'(a_reg) <= PW'(QF_LATCH_HI));

    assign v_abs = v_reg[DW-1] ? -(DW+1)'(v_reg) : (DW+1)'(v_reg);
    assign u_abs = u_reg[UW-1] ? -u_reg : u_reg;

    always_comb
    begin
        if (PW'(v_abs) <= PW'(QF_VEL_SMALL) && PW'(u_abs) >= PW'(QF_F_SMALL))
            u_comp = u_reg[UW-1] ? u_reg - UW'(QF_COMP_SIGN) : u_reg + UW'(QF_COMP_SIGN);
        else
            u_comp = u_reg + UW'(sh_30);
    end

    assign bal_force = clip(PW'(u_comp), BAL_SAT);

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_COS_M:
            begin
                mul_a = MW'(a_reg);
                mul_b = MW'(INV2PI_Q32);
            end
            ST_COS_IDX:
            begin
                mul_a = MW'(w_reg);
                mul_b = MW'(w_reg);
            end
            ST_KE_M:
            begin
                mul_a = r1_reg;
                mul_b = MW'(HALF_I_Q30);
            end
            ST_PE_M:
            begin
                mul_a = MW'(c_reg) + MW'(QF_ONE);
                mul_b = MW'(MGL_Q30);
            end
            ST_P_M:
            begin
                mul_a = r1_reg;
                mul_b = MW'(w_reg);
            end
            ST_Q_M:
            begin
                mul_a = r1_reg;
                mul_b = MW'(c_reg);
            end
            ST_K_M:
            begin
                mul_a = r1_reg;
                mul_b = MW'(KSWING_Q30);
            end
            ST_DR_M:
            begin
                mul_a = MW'(v_reg);
                mul_b = MW'(DRIFT_Q40);
            end
            ST_E1:
            begin
                mul_a = MW'(gain_position_reg);
                mul_b = MW'(x_reg) - MW'(target_position_reg);
            end
            ST_E2:
            begin
                mul_a = MW'(gain_velocity_reg);
                mul_b = MW'(v_reg) - MW'(target_velocity_reg);
            end
            ST_E3:
            begin
                mul_a = MW'(gain_angle_reg);
                mul_b = MW'(a_reg) - MW'(at_reg);
            end
            ST_E4:
            begin
                mul_a = MW'(gain_rate_reg);
                mul_b = MW'(w_reg) - MW'(target_rate_reg);
            end
            ST_TH_M:
            begin
                mul_a = MW'(v_abs);
                mul_b = MW'(TANH_SCALE);
            end
            ST_TC_M:
            begin
                mul_a = r1_reg;
                mul_b = MW'(COMP_TANH_Q30);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (in_zero)
                        state_next = ST_DONE;
                    else if (bal_reg)
                        state_next = ST_DR_M;
                    else
                        state_next = ST_COS_M;
                end
            end
            ST_COS_M:   state_next = ST_COS_IDX;
            ST_COS_IDX: state_next = ST_KE_WW;
            ST_KE_WW:   state_next = ST_KE_M;
            ST_KE_M:    state_next = ST_KE;
            ST_KE:      state_next = ST_PE_M;
            ST_PE_M:    state_next = ST_GATE;
            ST_GATE:    state_next = (PW'(c_reg) > PW'(QF_COS_GATE)) ? ST_P_M : ST_SW_END;
            ST_P_M:     state_next = ST_P;
            ST_P:       state_next = ST_Q_M;
            ST_Q_M:     state_next = ST_Q;
            ST_Q:       state_next = ST_K_M;
            ST_K_M:     state_next = ST_SW_END;
            ST_SW_END:  state_next = ST_DONE;
            ST_DR_M:    state_next = ST_DR;
            ST_DR:      state_next = ST_E1;
            ST_E1:      state_next = ST_E2;
            ST_E2:      state_next = ST_E3;
            ST_E3:      state_next = ST_E4;
            ST_E4:      state_next = ST_E5;
            ST_E5:      state_next = ST_TH_M;
            ST_TH_M:    state_next = ST_TH_IDX;
            ST_TH_IDX:  state_next = ST_TH_SEL;
            ST_TH_SEL:  state_next = ST_TC_M;
            ST_TC_M:    state_next = ST_BAL_END;
            ST_BAL_END: state_next = ST_DONE;
            ST_DONE:    state_next = out_free ? ST_IDLE : ST_DONE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Control state, configuration and persistent controller state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= ST_IDLE;
            m_tvalid_reg        <= 1'b0;
            bal_reg             <= 1'b0;
            at_reg              <= DW'(QF_PI);
            gain_position_reg   <= '0;
            gain_velocity_reg   <= '0;
            gain_angle_reg      <= '0;
            gain_rate_reg       <= '0;
            target_position_reg <= '0;
            target_velocity_reg <= '0;
            target_rate_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_DONE && out_free)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
            if (state_reg == ST_SW_END && latch_hit)
                bal_reg <= 1'b1;
            if (state_reg == ST_DR)
                at_reg <= at_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_GAIN_POSITION:   gain_position_reg   <= cfg_data;
                    CFG_GAIN_VELOCITY:   gain_velocity_reg   <= cfg_data;
                    CFG_GAIN_ANGLE:      gain_angle_reg      <= cfg_data;
                    CFG_GAIN_RATE:       gain_rate_reg       <= cfg_data;
                    CFG_TARGET_POSITION: target_position_reg <= cfg_data[DW-1:0];
                    CFG_TARGET_VELOCITY: target_velocity_reg <= cfg_data[DW-1:0];
                    CFG_TARGET_RATE:     target_rate_reg     <= cfg_data[DW-1:0];
                    default:             ;
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                a_reg     <= s_tdata[23:0];
                w_reg     <= s_tdata[47:24];
                x_reg     <= s_tdata[71:48];
                v_reg     <= s_tdata[95:72];
                force_reg <= '0;
            end
            ST_KE_WW:
            begin
                c_reg  <= cos_q;
                r1_reg <= MW'(sh_f);
            end
            ST_KE:   r2_reg <= MW'(sh_30);
            ST_GATE: 
            begin
                r1_reg   <= r2_reg - MW'(sh_30);
                gate_reg <= (PW'(c_reg) > PW'(QF_COS_GATE));
            end
            ST_P:    r1_reg <= MW'(sh_f);
            ST_Q:    r1_reg <= MW'(clip(sh_f, Q_LIM));
            ST_SW_END:
            begin
                force_reg <= gate_reg ? OUT_W'(clip(sh_30, SWING_SAT)) : '0;
            end
            ST_E1:   acc_reg <= '0;
            ST_E2:   acc_reg <= acc_reg + AW'(prod);
            ST_E3:   acc_reg <= acc_reg + AW'(prod);
            ST_E4:   acc_reg <= acc_reg + AW'(prod);
            ST_E5:   acc_reg <= acc_reg + AW'(prod);
            ST_TH_M: u_reg   <= -UW'(acc_sh);
            ST_TH_IDX:
            begin
                sat_reg <= (tanh_sum[PW-1:FRAC_BITS+3+TW] != '0);
            end
            ST_TH_SEL:
            begin
                if (sat_reg)
                    r1_reg <= v_reg[DW-1] ? -MW'(QF_ONE) : MW'(QF_ONE);
                else
                    r1_reg <= v_reg[DW-1] ? -MW'(tanh_q) : MW'(tanh_q);
            end
            ST_BAL_END: force_reg <= OUT_W'(bal_force);
            ST_DONE:
            begin
                if (out_free)
                begin
                    m_force_reg <= force_reg;
                    m_bal_reg   <= bal_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(24 - OUT_W){1'b0}}, m_force_reg};
    assign m_tuser  = m_bal_reg;

`ifndef NO_ASSERTIONS
    // Balance mode latches and is never left.
    assert property (@(posedge clk) disable iff (!rst_n) bal_reg |=> bal_reg)
        else $error("balance mode was left");

    // The angle target only moves in balance mode.
    assert property (@(posedge clk) disable iff (!rst_n) !bal_reg |-> at_reg == DW'(QF_PI))
        else $error("angle target moved during swing-up");

    // A beat starts work, so the next beat waits.
    assert property (@(posedge clk) disable iff (!rst_n) s_tvalid && s_tready |=> !s_tready)
        else $error("input taken twice in a row");

    // Every delivered force lies within the balance saturation band.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_force_reg) <= $signed(OUT_W'(BAL_SAT)))
                  && ($signed(m_force_reg) >= -$signed(OUT_W'(BAL_SAT))))
        else $error("force out of range");
`endif

endmodule

[src/psbc_mul.sv]
// Shared signed multiplier with a registered product.
// Depends on psbc_pkg for the operand width.
module psbc_mul
    import psbc_pkg::*;
(
    input  logic                 clk,
    input  logic signed [MW-1:0] op_a,
    input  logic signed [MW-1:0] op_b,
    output logic signed [PW-1:0] prod
);

    logic signed [PW-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

[src/psbc_tables.sv]
// Cosine and tanh lookup tables with registered reads.
// Contents are generated at elaboration by functions in psbc_pkg.
module psbc_tables
    import psbc_pkg::*;
(
    input  logic                 clk,
    input  logic [TW-1:0]        cos_idx,
    input  logic [TW-1:0]        tanh_idx,
    output logic signed [CW-1:0] cos_q,
    output logic signed [CW-1:0] tanh_q
);

    localparam rom_t COS_ROM  = make_cos_rom();
    localparam rom_t TANH_ROM = make_tanh_rom();

    logic signed [CW-1:0] cos_reg;
    logic signed [CW-1:0] tanh_reg;

    always_ff @(posedge clk)
    begin
        cos_reg  <= COS_ROM[cos_idx];
        tanh_reg <= TANH_ROM[tanh_idx];
    end

    assign cos_q  = cos_reg;
    assign tanh_q = tanh_reg;

endmodule

[test/pendulum_swingup_balance_controller_test.sv]
// Self-checking testbench for the pendulum swing-up and balance controller.
// Depends on psbc_pkg for port widths, register indexes and Q30 constants; predicts every beat.
module pendulum_swingup_balance_controller_test;
    import psbc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_CYCLES = 20000;

    typedef struct {
        logic [23:0] force_word;
        logic        balancing;
    } force_beat_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_index;
    logic [GW-1:0]    cfg_data;
    logic             s_tvalid;
    logic             s_tready;
    logic [95:0]      s_tdata;   // pend_angle, pend_rate, cart_position, cart_velocity
    logic             m_tvalid;
    logic             m_tready;
    logic [23:0]      m_tdata;   // force_res, zero fill
    logic [0:0]       m_tuser;   // balancing

    pendulum_swingup_balance_controller i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // Predictor state and its own copy of the registers.
    longint      cos_lut [TABLE_ENTRIES];
    longint      tanh_lut [TABLE_ENTRIES];
    longint      k_pos, k_vel, k_ang, k_rate;
    longint      ref_pos, ref_vel, ref_rate;
    bit          in_balance;
    longint      theta_ref;
    force_beat_t pending_forces [$];

    int          mismatches;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          quiet_cycles;

    function automatic longint round_shift(longint v, int s);
        longint mag;
        mag = (v < 0) ? -v : v;
        mag = (mag + (longint'(1) <<< (s - 1))) >>> s;
        return (v < 0) ? -mag : mag;
    endfunction

    function automatic longint sat(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint to_q(longint c30);
        return (c30 + (longint'(1) <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
    endfunction

    function automatic longint s24(logic [23:0] v);
        return longint'(signed'(v));
    endfunction

    // Quarter-wave Taylor series of cos on a turn fraction, Q30 result.
    function automatic longint turn_cos(longint t);
        longint quad;
        longint a;
        longint x;
        longint x2;
        longint term;
        longint acc;
        quad = t >>> 30;
        a = t & 64'h3FFF_FFFF;
        if (quad == 1 || quad == 3)
            a = (longint'(1) <<< 30) - a;
        x = (a * HALFPI_Q30) >>> 30;
        x2 = (x * x) >>> 30;
        term = longint'(1) <<< 30;
        acc = term;
        for (int k = 1; k <= 10; k++)
        begin
            term = ((term * x2) >>> 30) / longint'((2 * k - 1) * (2 * k));
            acc = (k % 2 == 1) ? acc - term : acc + term;
        end
        acc = sat(acc, 0, longint'(1) <<< 30);
        return (quad == 1 || quad == 2) ? -acc : acc;
    endfunction

    function automatic longint decay_q30(longint z);
        longint whole;
        longint fpart;
        longint term;
        longint acc;
        whole = z >>> 30;
        fpart = z & 64'h3FFF_FFFF;
        term = longint'(1) <<< 30;
        acc = term;
        if (whole > 40)
            return 0;
        for (int k = 1; k <= 12; k++)
        begin
            term = ((term * fpart) >>> 30) / longint'(k);
            acc = (k % 2 == 1) ? acc - term : acc + term;
        end
        acc = sat(acc, 0, longint'(1) <<< 30);
        for (longint k = 0; k < whole; k++)
            acc = (acc * EINV_Q30 + (longint'(1) <<< 29)) >>> 30;
        return acc;
    endfunction

    function automatic void fill_luts();
        longint e;
        longint th;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            cos_lut[i] = round_shift(turn_cos((longint'(i) <<< 32) / TABLE_ENTRIES),
                                     30 - FRAC_BITS);
            e = decay_q30((longint'(i) <<< 34) / TABLE_ENTRIES);
            th = (((longint'(1) <<< 30) - e) <<< 30) / ((longint'(1) <<< 30) + e);
            tanh_lut[i] = round_shift(th, 30 - FRAC_BITS);
        end
    endfunction

    function automatic longint cos_of(longint ang);
        logic [63:0] turns;
        logic [63:0] idx;
        turns = 64'(ang) * 64'(INV2PI_Q32);
        idx = ({32'b0, turns[FRAC_BITS +: 32]} * TABLE_ENTRIES + (64'd1 << 31)) >> 32;
        if (idx >= TABLE_ENTRIES)
            idx = idx - TABLE_ENTRIES;
        return cos_lut[idx];
    endfunction

    function automatic longint tanh_of_100v(longint v);
        longint mag;
        longint idx;
        longint t;
        mag = (v < 0) ? -v : v;
        idx = (mag * 100 * TABLE_ENTRIES + (longint'(1) <<< (FRAC_BITS + 2))) >>> (FRAC_BITS + 3);
        t = (idx >= TABLE_ENTRIES) ? (longint'(1) <<< FRAC_BITS) : tanh_lut[idx];
        return (v < 0) ? -t : t;
    endfunction

    function automatic longint pump_force(longint a, longint w);
        longint c;
        longint kin;
        longint pot;
        longint p;
        longint q;
        longint u;
        c = cos_of(a);
        kin = round_shift(round_shift(w * w, FRAC_BITS) * HALF_I_Q30, 30);
        pot = round_shift((c + (longint'(1) <<< FRAC_BITS)) * MGL_Q30, 30);
        u = 0;
        if (c > to_q(COS_GATE_Q30))
        begin
            p = round_shift((kin - pot) * w, FRAC_BITS);
            q = sat(round_shift(p * c, FRAC_BITS), -(longint'(64) <<< FRAC_BITS),
                    longint'(64) <<< FRAC_BITS);
            u = round_shift(q * KSWING_Q30, 30);
        end
        u = sat(u, -(longint'(20) <<< FRAC_BITS), longint'(20) <<< FRAC_BITS);
        if (a >= to_q(LATCH_LO_Q30) && a <= to_q(LATCH_HI_Q30))
            in_balance = 1'b1;
        return u;
    endfunction

    function automatic longint lqr_force(longint a, longint w, longint x, longint v);
        longint acc;
        longint u;
        longint lim;
        theta_ref = sat(theta_ref + round_shift(v * DRIFT_Q40, 40), -64'sd8388608, 64'sd8388607);
        acc = k_pos * (x - ref_pos) + k_vel * (v - ref_vel) + k_ang * (a - theta_ref)
            + k_rate * (w - ref_rate);
        u = -round_shift(acc, 16);
        if (((v < 0) ? -v : v) <= to_q(VEL_SMALL_Q30)
            && ((u < 0) ? -u : u) >= to_q(FORCE_SMALL_Q30))
            u = u + ((u < 0) ? -to_q(COMP_SIGN_Q30) : to_q(COMP_SIGN_Q30));
        else
            u = u + round_shift(tanh_of_100v(v) * COMP_TANH_Q30, 30);
        lim = longint'(25) <<< FRAC_BITS;
        return sat(u, -lim, lim);
    endfunction

    function automatic force_beat_t predict_force(logic [95:0] word);
        longint      a;
        longint      w;
        longint      f;
        logic [63:0] fbits;
        force_beat_t r;
        a = s24(word[23:0]);
        w = s24(word[47:24]);
        f = 0;
        if (a != 0 || w != 0)
            f = in_balance ? lqr_force(a, w, s24(word[71:48]), s24(word[95:72]))
                           : pump_force(a, w);
        fbits = 64'(f);
        r.force_word = {2'b00, fbits[OUT_W-1:0]};
        r.balancing = in_balance;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [23:0] got, logic [23:0] want);
        $display("mismatch on %s: got %h, expected %h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    // Result checker.
    always @(posedge clk)
    begin
        force_beat_t want;
        if (m_tvalid && m_tready)
        begin
            if (pending_forces.size() == 0)
                report_mismatch("unexpected beat", m_tdata, 24'h0);
            else
            begin
                want = pending_forces.pop_front();
                if (m_tdata !== want.force_word)
                    report_mismatch("force", m_tdata, want.force_word);
                if (m_tuser[0] !== want.balancing)
                    report_mismatch("balancing", 24'(m_tuser), 24'(want.balancing));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_CYCLES)
        begin
            $display("[pendulum_swingup_balance_controller] ERROR");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_state(logic [23:0] a, logic [23:0] w, logic [23:0] x, logic [23:0] v);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {v, x, w, a};
        do
            @(posedge clk);
        while (!s_tready);
        pending_forces.push_back(predict_force(s_tdata));
        @(negedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        wait (pending_forces.size() == 0);
        repeat (30)
            @(negedge clk);
    endtask

    task automatic load_gains(logic [31:0] kx, logic [31:0] kv, logic [31:0] ka,
                              logic [31:0] kw, logic [23:0] px, logic [23:0] pv,
                              logic [23:0] pw);
        logic [31:0] vals [7];
        logic [CFG_W-1:0] idx [7];
        vals = '{kx, kv, ka, kw, 32'(px), 32'(pv), 32'(pw)};
        idx = '{CFG_GAIN_POSITION, CFG_GAIN_VELOCITY, CFG_GAIN_ANGLE, CFG_GAIN_RATE,
                CFG_TARGET_POSITION, CFG_TARGET_VELOCITY, CFG_TARGET_RATE};
        for (int i = 0; i < 7; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= vals[i];
            @(negedge clk);
        end
        cfg_we <= 1'b0;
        k_pos = longint'(signed'(kx));
        k_vel = longint'(signed'(kv));
        k_ang = longint'(signed'(ka));
        k_rate = longint'(signed'(kw));
        ref_pos = s24(px);
        ref_vel = s24(pv);
        ref_rate = s24(pw);
        @(negedge clk);
    endtask

    function automatic logic [23:0] any_s24(int small_mag);
        case ($urandom_range(9))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'h000000;
            3, 4, 5, 6: return 24'($signed($urandom_range(2 * small_mag)) - small_mag);
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] any_gain();
        case ($urandom_range(7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3: return $urandom;
            default: return 32'($signed($urandom_range(200 << 16)) - (100 << 16));
        endcase
    endfunction

    // Swing-up angles stay out of the latch window so the mode is not taken early.
    function automatic logic [23:0] swing_angle();
        logic [23:0] a;
        do
            a = ($urandom_range(3) != 0) ? any_s24(45000) : 24'($urandom);
        while (s24(a) >= to_q(LATCH_LO_Q30) && s24(a) <= to_q(LATCH_HI_Q30));
        return a;
    endfunction

    task automatic set_idling(int send_pct, int recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    task automatic test_idle_state_swing();
        send_state(24'h0, 24'h0, 24'h7FFFFF, 24'h800000);
        send_state(24'h0, 24'h000001, 24'h0, 24'h0);
        send_state(24'h0, 24'h800000, 24'h0, 24'h0);
        send_state(24'h0, 24'h7FFFFF, 24'h0, 24'h0);
    endtask

    task automatic test_swing_pumping();
        send_state(24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h7FFFFF);
        send_state(24'h800000, 24'h800000, 24'h7FFFFF, 24'h800000);
        send_state(24'h002000, 24'h050000, 24'h0, 24'h0);    // gated in, small rate
        send_state(24'hFFE000, 24'hFB0000, 24'h0, 24'h0);
        send_state(24'h010000, 24'h030000, 24'h0, 24'h0);    // cos below the gate
        send_state(24'h001000, 24'h200000, 24'h0, 24'h0);    // saturates
        send_state(24'h064880, 24'h010000, 24'h0, 24'h0);    // near two pi wraps the table
    endtask

    task automatic test_swing_random(int count);
        for (int i = 0; i < count; i++)
            send_state(swing_angle(), any_s24(8 << 16), any_s24(3 << 16), any_s24(3 << 16));
    endtask

    task automatic test_latch();
        send_state(24'(to_q(LATCH_LO_Q30)), 24'h008000, 24'h0, 24'h0);
        send_state(24'h0, 24'h0, 24'h0, 24'h0);    // zero beat reports balance mode
    endtask

    task automatic test_balance_directed();
        send_state(24'(to_q(PI_Q30) + 3000), 24'h0, 24'h0, 24'h000100);   // sign compensation
        send_state(24'(to_q(PI_Q30)), 24'h0, 24'h0, 24'hFFFF00);          // tiny force
        send_state(24'(to_q(PI_Q30) - 3000), 24'h001000, 24'h0, 24'(-3277));
        send_state(24'(to_q(PI_Q30)), 24'h0, 24'h0, 24'h7FFFFF);          // tanh at one
        send_state(24'h7FFFFF, 24'h800000, 24'h800000, 24'h800000);
        send_state(24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h000CCD);
    endtask

    task automatic test_balance_random(int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(19) == 0)
                send_state(24'h0, 24'h0, any_s24(1 << 16), any_s24(1 << 16));
            else
                send_state(24'(to_q(PI_Q30) + s24(any_s24(20000))), any_s24(2 << 16),
                           any_s24(1 << 16), ($urandom_range(2) == 0) ? any_s24(4000)
                                                                       : any_s24(1 << 16));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_GAIN_POSITION;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        k_pos = 0;
        k_vel = 0;
        k_ang = 0;
        k_rate = 0;
        ref_pos = 0;
        ref_vel = 0;
        ref_rate = 0;
        in_balance = 1'b0;
        theta_ref = to_q(PI_Q30);
        set_idling(0, 0);
        fill_luts();
        repeat (7)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_idle_state_swing();
        test_swing_pumping();
        set_idling(0, 0);
        test_swing_random(150);
        set_idling(74, 0);
        test_swing_random(150);
        set_idling(0, 74);
        test_swing_random(150);
        set_idling(35, 35);
        test_swing_random(150);
        set_idling(0, 0);
        test_latch();
        drain();

        load_gains(32'(-1 <<< 16), 32'(-2 <<< 16), 32'(40 <<< 16), 32'(5 <<< 16),
                   24'h0, 24'h0, 24'h0);
        test_balance_directed();
        for (int phase = 0; phase < 8; phase++)
        begin
            drain();
            case (phase)
                0: load_gains(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                              24'h7FFFFF, 24'h800000, 24'h7FFFFF);
                1: load_gains(32'h0, 32'h0, 32'h0, 32'h0, 24'h800000, 24'h7FFFFF, 24'h800000);
                2: load_gains(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0100, 32'h0,
                              24'h000100, 24'hFFFF00, 24'h0);
                default: load_gains(any_gain(), any_gain(), any_gain(), any_gain(),
                                    any_s24(1 << 16), any_s24(1 << 16), any_s24(1 << 16));
            endcase
            case (phase % 4)
                0: set_idling(0, 0);
                1: set_idling(74, 0);
                2: set_idling(0, 74);
                default: set_idling(35, 35);
            endcase
            test_balance_random(140);
        end

        drain();
        if (mismatches == 0)
            $display("[pendulum_swingup_balance_controller] OK");
        else
            $display("[pendulum_swingup_balance_controller] ERROR");
        $finish;
    end

endmodule
